[design/mtf_pkg.sv]
package mtf_pkg;

    // opcodes of an input word
    localparam logic [1:0] OP_TOUCH  = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam int unsigned ID_W  = 32;
    localparam int unsigned POS_W = 3;

    typedef struct packed {
        logic [1:0]      opcode;
        logic [ID_W-1:0] entry_id;
    } mtf_in_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] found_position;
    } mtf_out_t;

    // command broadcast to every cell of the list
    typedef struct packed {
        logic            touch;
        logic            remove;
        logic            key_ok;
        logic [ID_W-1:0] key;
    } mtf_cmd_t;

endpackage

[design/mru_move_to_front_list_unit.sv]
// move-to-front most-recently-used list of 32-bit entry ids
//
// input channel: in_valid / in_ready / in_word (opcode, entry_id)
//   opcode touch moves the id to the front (inserting it and dropping the
//   oldest entry when absent), remove deletes it and closes the gap, query
//   and the unused code only report; id zero marks an empty slot and is
//   never found
// output channel: out_valid / out_ready / out_word (found, found_position)
//   exactly one word per input word, in order
// timing: the result word is shown in the cycle after its input is accepted
// throughput: one word per cycle while results are taken; the list is a chain of LIST_DEPTH cells,
//   each comparing its id with the key and loading from a neighbor in the
//   same cycle, so the match ripple along the chain sets the clock path
// stall: while a result waits and out_ready is low, in_ready is low; once
//   the result is taken, a new word is accepted in that same cycle
// reset: rst_n clears every slot (list empty) and drops out_valid
module mru_move_to_front_list_unit #(
    parameter int unsigned LIST_DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mtf_pkg::mtf_in_t  in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output mtf_pkg::mtf_out_t out_word
);
    import mtf_pkg::*;

    logic            accept;
    mtf_cmd_t        cmd;

    // neighbor links of the cell chain
    logic [ID_W-1:0]  cell_id   [LIST_DEPTH];
    logic [ID_W-1:0]  cell_prev [LIST_DEPTH];
    logic [ID_W-1:0]  cell_nxt  [LIST_DEPTH];
    logic [LIST_DEPTH:0]   match_chain;
    logic [LIST_DEPTH-1:0] hit_vec;
    logic [POS_W-1:0] pos_vec   [LIST_DEPTH];

    logic [POS_W-1:0] hit_pos;
    logic             out_valid_reg;
    mtf_out_t         out_word_reg;

    // output register frees up whenever its word is taken
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.key    = in_word.entry_id;
        cmd.key_ok = (in_word.entry_id != '0);
        unique case (in_word.opcode)
            OP_TOUCH:  cmd.touch  = accept && cmd.key_ok;
            OP_REMOVE: cmd.remove = accept && cmd.key_ok;
            OP_QUERY:  ;
            default:   ;  // unused code behaves as a query
        endcase
    end

    assign match_chain[0] = 1'b0;

    genvar k;
    generate
        for (k = 0; k < LIST_DEPTH; k++)
        begin : g_cell
            // the key enters at the front, zero fills in at the back
            if (k == 0)
            begin : g_front
                assign cell_prev[k] = cmd.key;
            end
            else
            begin : g_mid_front
                assign cell_prev[k] = cell_id[k-1];
            end

            if (k == LIST_DEPTH - 1)
            begin : g_back
                assign cell_nxt[k] = '0;
            end
            else
            begin : g_mid_back
                assign cell_nxt[k] = cell_id[k+1];
            end

            mtf_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .prev_id   (cell_prev[k]),
                .next_id   (cell_nxt[k]),
                .match_in  (match_chain[k]),
                .match_out (match_chain[k+1]),
                .hit_here  (hit_vec[k]),
                .id        (cell_id[k])
            );

            // ids are unique, so at most one cell contributes its position
            assign pos_vec[k] = hit_vec[k] ? POS_W'(k) : '0;
        end
    endgenerate

    always_comb
    begin
        hit_pos = '0;
        for (int unsigned j = 0; j < LIST_DEPTH; j++)
        begin
            hit_pos = hit_pos | pos_vec[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_word_reg.found          <= match_chain[LIST_DEPTH];
            out_word_reg.found_position <= hit_pos;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

[design/mtf_cell.sv]
module mtf_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mtf_pkg::mtf_cmd_t        cmd,
    input  logic [mtf_pkg::ID_W-1:0] prev_id,
    input  logic [mtf_pkg::ID_W-1:0] next_id,
    input  logic                     match_in,
    output logic                     match_out,
    output logic                     hit_here,
    output logic [mtf_pkg::ID_W-1:0] id
);
    import mtf_pkg::*;

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;

    assign hit_here  = cmd.key_ok && (id_reg == cmd.key);
    assign match_out = match_in | hit_here;
    assign id        = id_reg;

    always_comb
    begin
        id_next = id_reg;
        // touch: every slot up to and including the hit (or all on a miss) moves back
        if (cmd.touch && !match_in)
        begin
            id_next = prev_id;
        end
        // remove: the hit slot and all behind it move forward
        else if (cmd.remove && match_out)
        begin
            id_next = next_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg <= '0;
        end
        else
        begin
            id_reg <= id_next;
        end
    end

endmodule

[design/mtf_checker.sv]
module mtf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input mtf_pkg::mtf_in_t  in_word,
    input logic              out_valid,
    input logic              out_ready,
    input mtf_pkg::mtf_out_t out_word
);
    import mtf_pkg::*;

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    // a miss always reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.found || out_word.found_position == '0))
        else $error("miss word with nonzero position");

    // id zero is never found, and its result follows in the next cycle
    a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_word.entry_id == '0) |=> (out_valid && !out_word.found))
        else $error("id zero reported as found");

    // a query right after a touch of the same id sees it at the front
    a_touch_front: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_word.opcode == OP_QUERY
            && $past(in_acc && in_word.opcode == OP_TOUCH && in_word.entry_id != '0)
            && in_word.entry_id == $past(in_word.entry_id))
        |=> (out_valid && out_word.found && out_word.found_position == '0))
        else $error("touched id not at front");

    // an empty output register never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no pending word");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
        else $error("result word changed while stalled");

endmodule

bind mru_move_to_front_list_unit mtf_checker u_mtf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

[tb/mru_move_to_front_list_unit_tb.sv]
`timescale 1ns / 1ps

module mru_move_to_front_list_unit_tb;

    import mtf_pkg::*;

    localparam int unsigned LIST_DEPTH  = 8;
    localparam int unsigned POOL_SIZE   = 11;
    localparam int unsigned RANDOM_WORDS = 730;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_WAIT  = 8;

    // the package names no code for opcode three; the block treats it as a query
    localparam logic [1:0] OP_SPARE = 2'd3;

    // one pending input word, optionally held back until the block is empty
    typedef struct {
        mtf_in_t word;
        bit      drain_first;
    } pending_word_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    mtf_in_t   in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    mtf_out_t  out_word;

    // shadow of the list, newest id in slot zero, zero marks an empty slot
    logic [ID_W-1:0] mru_ids [LIST_DEPTH];
    logic [ID_W-1:0] id_pool [POOL_SIZE];

    pending_word_t pending_words[$];
    mtf_out_t      predicted_hits[$];

    int words_accepted = 0;
    int words_returned = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    // sender burst shaping
    int burst_left = 1;
    int gap_left   = 0;

    // receiver stall shaping
    int ready_mode    = 0;
    int mode_left     = 0;
    int hold_left     = 0;
    int next_hold_at  = 120;

    mru_move_to_front_list_unit #(
        .LIST_DEPTH (LIST_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always #1 clk = ~clk;

    // predicts the result of one accepted word and updates the shadow list
    function automatic mtf_out_t predict_mru(mtf_in_t w);
        mtf_out_t res;
        int       hit_slot;
        int       top;
        hit_slot = -1;
        // id zero is the empty marker and never matches
        if (w.entry_id != '0) begin
            for (int k = 0; k < LIST_DEPTH; k++) begin
                if (hit_slot < 0 && mru_ids[k] == w.entry_id)
                    hit_slot = k;
            end
        end
        res.found          = (hit_slot >= 0);
        res.found_position = (hit_slot >= 0) ? POS_W'(hit_slot) : '0;
        if (w.entry_id != '0) begin
            if (w.opcode == OP_TOUCH) begin
                // a hit shifts the slots ahead of it, a miss drops the oldest
                top = (hit_slot >= 0) ? hit_slot : LIST_DEPTH - 1;
                for (int k = top; k > 0; k--)
                    mru_ids[k] = mru_ids[k-1];
                mru_ids[0] = w.entry_id;
            end else if (w.opcode == OP_REMOVE && hit_slot >= 0) begin
                // close the gap and leave the last slot empty
                for (int k = hit_slot; k < LIST_DEPTH - 1; k++)
                    mru_ids[k] = mru_ids[k+1];
                mru_ids[LIST_DEPTH-1] = '0;
            end
        end
        return res;
    endfunction

    function automatic void queue_word(logic [1:0] op, logic [ID_W-1:0] id, bit drain);
        pending_word_t p;
        p.word.opcode   = op;
        p.word.entry_id = id;
        p.drain_first   = drain;
        pending_words.push_back(p);
    endfunction

    // ids mostly come from a small pool a little larger than the list, so
    // hits, moves, evictions and removes all happen often
    function automatic logic [ID_W-1:0] pick_id();
        logic [ID_W-1:0] id;
        case ($urandom_range(0, 19))
            0:       id = '0;
            1, 2, 3: id = $urandom;
            default: id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        endcase
        return id;
    endfunction

    function automatic logic [1:0] pick_opcode();
        logic [1:0] op;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: op = OP_TOUCH;
            5, 6:          op = OP_REMOVE;
            7, 8:          op = OP_QUERY;
            default:       op = OP_SPARE;
        endcase
        return op;
    endfunction

    // sender: offers pending words in bursts with random gaps; a word held
    // is kept stable until it is accepted, and a word marked drain_first
    // waits until every result of earlier words has come back
    always @(posedge clk or negedge rst_n) begin
        logic    next_valid;
        mtf_in_t next_word;
        logic    drained;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_word  <= '0;
        end else begin
            next_valid = in_valid;
            next_word  = in_word;
            if (in_valid && in_ready) begin
                predicted_hits.push_back(predict_mru(in_word));
                words_accepted++;
                pending_words.delete(0);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                // words_returned is updated late, so count a result leaving now
                drained = (words_accepted == words_returned + int'(out_valid && out_ready));
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() > 0 &&
                             (!pending_words[0].drain_first || drained)) begin
                    next_valid = 1'b1;
                    next_word  = pending_words[0].word;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            in_valid <= next_valid;
            in_word  <= next_word;
        end
    end

    // receiver: the stall pattern is picked anew at random, and a few
    // times a long hold-off lets the block fill up and push back
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (hold_left == 0 && words_returned >= next_hold_at) begin
                hold_left    = 60;
                next_hold_at = next_hold_at + 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(8, 64);
                end
                mode_left--;
                case (ready_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // monitor: every result word is checked against the oldest prediction
    always @(posedge clk) begin
        mtf_out_t want;
        if (rst_n && out_valid && out_ready) begin
            words_returned <= words_returned + 1;
            if (predicted_hits.size() == 0) begin
                $error("result word with nothing expected: found %0b found_position %0d",
                       out_word.found, out_word.found_position);
                mismatches++;
            end else begin
                want = predicted_hits.pop_front();
                if (out_word.found !== want.found) begin
                    $error("found: expected %0b, actual %0b", want.found, out_word.found);
                    mismatches++;
                end
                if (out_word.found_position !== want.found_position) begin
                    $error("found_position: expected %0d, actual %0d",
                           want.found_position, out_word.found_position);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < LIST_DEPTH; k++)
            mru_ids[k] = '0;
        id_pool[0] = 32'hFFFF_FFFF;
        id_pool[1] = 32'h0000_0001;
        id_pool[2] = 32'h8000_0000;
        for (int k = 3; k < POOL_SIZE; k++)
            id_pool[k] = $urandom;

        // directed: misses on an empty list, id zero, filling and eviction
        queue_word(OP_QUERY, 32'd5, 1'b0);
        queue_word(OP_TOUCH, 32'd0, 1'b0);
        queue_word(OP_REMOVE, 32'd0, 1'b0);
        for (int k = 1; k <= 8; k++)
            queue_word(OP_TOUCH, ID_W'(k), 1'b0);
        queue_word(OP_TOUCH, 32'hFFFF_FFFF, 1'b0);
        queue_word(OP_QUERY, 32'd1, 1'b0);
        // touch of the front id, touch of the oldest id
        queue_word(OP_TOUCH, 32'hFFFF_FFFF, 1'b0);
        queue_word(OP_TOUCH, 32'd2, 1'b0);
        queue_word(OP_QUERY, 32'd0, 1'b0);
        // the spare opcode only reports
        queue_word(OP_SPARE, 32'd5, 1'b0);
        // remove from the middle, then the same id again once it is gone
        queue_word(OP_REMOVE, 32'd5, 1'b0);
        queue_word(OP_REMOVE, 32'd5, 1'b0);
        // remove the oldest entry, then look for zero with an empty slot present
        queue_word(OP_REMOVE, 32'd3, 1'b0);
        queue_word(OP_QUERY, 32'd0, 1'b0);
        queue_word(OP_TOUCH, 32'd0, 1'b0);
        // remove the front, insert into a list with a free slot
        queue_word(OP_REMOVE, 32'd2, 1'b0);
        queue_word(OP_TOUCH, 32'h8000_0000, 1'b0);
        queue_word(OP_QUERY, 32'h8000_0000, 1'b0);

        // random words; now and then the sender waits for a drained block
        for (int i = 0; i < RANDOM_WORDS; i++)
            queue_word(pick_opcode(), pick_id(), (i % 150) == 0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || words_accepted != words_returned)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (predicted_hits.size() != 0) begin
            $error("%0d expected result words never arrived", predicted_hits.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
design/mtf_pkg.sv
design/mtf_cell.sv
design/mru_move_to_front_list_unit.sv
design/mtf_checker.sv
tb/mru_move_to_front_list_unit_tb.sv
